### src/tmw_pkg.sv
// Shared types and constants for the tone-map tile pixel writer.
// Holds field widths, register codes and the tone threshold table,
// which is built at elaboration time. No dependencies.
package tmw_pkg;

  localparam int ENERGY_W = 32;
  localparam int COORD_W  = 13;
  localparam int LOCAL_W  = 12;
  localparam int POS_W    = 14;   // origin plus local coordinate, signed
  localparam int CFG_W    = 13;
  localparam int ADDR_W   = 24;
  localparam int VALUE_W  = 8;
  localparam int IN_W     = 88;   // input fields padded to whole bytes
  localparam int OUT_W    = ADDR_W + VALUE_W;
  localparam int NUM_CODES = 256;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd1024;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd768;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic              in_frame;
    logic [ADDR_W-1:0] address;
  } addr_res_t;

  // Wide enough for E^11 * 255^20 (about 501 bits).
  localparam int BIG_W = 544;
  typedef logic [BIG_W-1:0] big_t;
  typedef logic [ENERGY_W-2:0] thresh_tab_t [NUM_CODES];

  function automatic big_t pow11(input big_t x);
    big_t x2;
    big_t x4;
    big_t x8;
    x2 = x * x;
    x4 = x2 * x2;
    x8 = x4 * x4;
    return x8 * x2 * x;
  endfunction

  function automatic big_t pow20(input big_t x);
    big_t x2;
    big_t x4;
    big_t x8;
    big_t x16;
    x2  = x * x;
    x4  = x2 * x2;
    x8  = x4 * x4;
    x16 = x8 * x8;
    return x16 * x4;
  endfunction

  // Entry k is the smallest raw energy E with E^11*255^20 >= k^20*(65536+E)^11.
  // Entry 0 always passes, entry 255 is never reached.
  function automatic thresh_tab_t build_thresholds();
    thresh_tab_t tab;
    big_t        c255;
    big_t        kp;
    longint      lo;
    longint      hi;
    longint      mid;
    c255 = pow20(big_t'(255));
    tab[0]   = '0;
    tab[255] = '1;
    for (int k = 1; k < NUM_CODES - 1; k++) begin
      kp = pow20(big_t'(k));
      lo = 1;
      hi = 64'h7FFF_FFFF;
      for (int it = 0; it < 32; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (pow11(big_t'(mid)) * c255 >= pow11(big_t'(mid + 65536)) * kp) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
      end
      tab[k] = lo[ENERGY_W-2:0];
    end
    return tab;
  endfunction

  localparam thresh_tab_t THRESH = build_thresholds();

endpackage

### src/tmw_tone.sv
// Tone curve: maps a signed Q16.16 energy to an 8-bit display code.
// Compares against the threshold table of tmw_pkg, then searches the
// resulting thermometer code for its top set bit.
module tmw_tone (
  input  logic [tmw_pkg::ENERGY_W-1:0] energy,
  output logic [tmw_pkg::VALUE_W-1:0]  pixel_value
);

  logic [tmw_pkg::NUM_CODES-1:0] reach;

  always_comb begin
    reach    = '0;
    reach[0] = 1'b1;
    for (int k = 1; k < tmw_pkg::NUM_CODES - 1; k++) begin
      reach[k] = !energy[tmw_pkg::ENERGY_W-1] &&
                 (energy[tmw_pkg::ENERGY_W-2:0] >= tmw_pkg::THRESH[k]);
    end
  end

  // reach is monotone, so a bitwise search finds the index of its top set bit
  always_comb begin
    logic [tmw_pkg::VALUE_W-1:0] code;
    logic [tmw_pkg::VALUE_W-1:0] probe;
    code = '0;
    for (int b = tmw_pkg::VALUE_W - 1; b >= 0; b--) begin
      probe = code | (8'b1 << b);
      if (reach[probe]) begin
        code = probe;
      end
    end
    pixel_value = code;
  end

endmodule

### src/tmw_addr.sv
// Frame position and bounds check: origin plus local coordinate,
// clamped frame size, linear address row * width + column.
// Depends on tmw_pkg.
module tmw_addr #(
  parameter int MAX_DIM = 4096
) (
  input  logic signed [tmw_pkg::COORD_W-1:0] origin_x,
  input  logic signed [tmw_pkg::COORD_W-1:0] origin_y,
  input  logic [tmw_pkg::LOCAL_W-1:0]        local_x,
  input  logic [tmw_pkg::LOCAL_W-1:0]        local_y,
  input  logic [tmw_pkg::CFG_W-1:0]          frame_width,
  input  logic [tmw_pkg::CFG_W-1:0]          frame_height,
  output tmw_pkg::addr_res_t                 res
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > tmw_pkg::POS_W) ? DIM_W : tmw_pkg::POS_W;
  localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIM);

  logic signed [tmw_pkg::POS_W-1:0] px;
  logic signed [tmw_pkg::POS_W-1:0] py;
  logic [CMP_W-1:0] fw_ext;
  logic [CMP_W-1:0] fh_ext;
  logic [CMP_W-1:0] fw_eff;
  logic [CMP_W-1:0] fh_eff;
  logic [CMP_W-1:0] px_u;
  logic [CMP_W-1:0] py_u;
  logic [tmw_pkg::ADDR_W-1:0] row_base;

  assign px = tmw_pkg::POS_W'(origin_x) + $signed({2'b00, local_x});
  assign py = tmw_pkg::POS_W'(origin_y) + $signed({2'b00, local_y});

  assign fw_ext = CMP_W'(frame_width);
  assign fh_ext = CMP_W'(frame_height);
  assign fw_eff = (fw_ext > DIM_MAX) ? DIM_MAX : fw_ext;
  assign fh_eff = (fh_ext > DIM_MAX) ? DIM_MAX : fh_ext;

  // sign bit is checked separately; lower bits are the magnitude when in frame
  assign px_u = CMP_W'(px[tmw_pkg::POS_W-2:0]);
  assign py_u = CMP_W'(py[tmw_pkg::POS_W-2:0]);

  assign row_base = tmw_pkg::ADDR_W'(py_u) * tmw_pkg::ADDR_W'(fw_eff);

  assign res.in_frame = !px[tmw_pkg::POS_W-1] && !py[tmw_pkg::POS_W-1] &&
                        (px_u < fw_eff) && (py_u < fh_eff);
  assign res.address  = row_base + tmw_pkg::ADDR_W'(px_u);

endmodule

### src/tonemap_tile_pixel_writer.sv
// Tone-map tile pixel writer, top level. Uses tmw_pkg, tmw_tone, tmw_addr.
// Path: input register, then result register, with the threshold compare
// and the row multiply between them. Throughput: one transaction per cycle
// while m_tready does not stall the result register.
// Reset (rst, synchronous): clears both valid flags and loads the frame
// size registers with 1024 x 768. Out-of-frame samples produce nothing.
module tonemap_tile_pixel_writer #(
  parameter int MAX_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [0:0]                   cfg_index,
  input  logic [tmw_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // energy[31:0], origin_x[44:32], origin_y[57:45], local_x[69:58],
  // local_y[81:70], zero pad[87:82]
  input  logic [tmw_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // pixel_address[23:0], pixel_value[31:24]
  output logic [tmw_pkg::OUT_W-1:0]    m_tdata
);

  logic [tmw_pkg::CFG_W-1:0] frame_width;
  logic [tmw_pkg::CFG_W-1:0] frame_height;

  logic                                in_valid;
  logic [tmw_pkg::ENERGY_W-1:0]        in_energy;
  logic signed [tmw_pkg::COORD_W-1:0]  in_origin_x;
  logic signed [tmw_pkg::COORD_W-1:0]  in_origin_y;
  logic [tmw_pkg::LOCAL_W-1:0]         in_local_x;
  logic [tmw_pkg::LOCAL_W-1:0]         in_local_y;

  logic                        out_valid;
  logic [tmw_pkg::ADDR_W-1:0]  out_address;
  logic [tmw_pkg::VALUE_W-1:0] out_value;

  logic                        advance;
  tmw_pkg::addr_res_t          addr_res;
  logic [tmw_pkg::VALUE_W-1:0] tone_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= tmw_pkg::FRAME_WIDTH_RESET;
      frame_height <= tmw_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (tmw_pkg::reg_index_t'(cfg_index))
        tmw_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        tmw_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // result slot frees when empty or taken this cycle
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_energy   <= s_tdata[31:0];
      in_origin_x <= s_tdata[44:32];
      in_origin_y <= s_tdata[57:45];
      in_local_x  <= s_tdata[69:58];
      in_local_y  <= s_tdata[81:70];
    end
  end

  tmw_tone u_tone (
    .energy      (in_energy),
    .pixel_value (tone_value)
  );

  tmw_addr #(
    .MAX_DIM (MAX_DIM)
  ) u_addr (
    .origin_x     (in_origin_x),
    .origin_y     (in_origin_y),
    .local_x      (in_local_x),
    .local_y      (in_local_y),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .res          (addr_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && addr_res.in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_address <= addr_res.address;
      out_value   <= tone_value;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_value, out_address};

  a_code_below_top: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:24] != 8'hFF))
    else $error("pixel value reached the unreachable top code");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |-> !s_tready)
    else $error("input taken while input register is stalled");

  a_negative_is_black: assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance && addr_res.in_frame && in_energy[31])
      |=> (m_tvalid && (m_tdata[31:24] == 8'h00)))
    else $error("negative energy produced a nonzero pixel");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_valid))
    else $error("result appeared without a pending transaction");

endmodule
